// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while rst is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Same-cycle implication built on the one above.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   `CHK_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

// ----- hdl/dmrs_pkg.sv -----
// Types and codes for the deduplicating message ring store.
package dmrs_pkg;

   // command codes
   localparam logic [2:0] CMD_PUBLISH  = 3'd0;
   localparam logic [2:0] CMD_GET      = 3'd1;
   localparam logic [2:0] CMD_SET      = 3'd2;
   localparam logic [2:0] CMD_SNAPSHOT = 3'd3;
   localparam logic [2:0] CMD_CLEAR    = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // width of the count fields in a response
   localparam int OUT_CNT_W = 7;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] lookup_id;
      logic        mark_flag;
      logic [63:0] key_hash;
      logic [1:0]  prio;
      logic [31:0] payload_tag;
      logic        content_ok;
      logic        unread_filter;
      logic [6:0]  snapshot_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        entry_valid;
      logic [31:0] entry_id;
      logic [1:0]  entry_prio;
      logic        entry_unread;
      logic [31:0] entry_payload;
      logic [6:0]  matched_total;
      logic [6:0]  stored_count;
      logic [6:0]  unread_count;
      logic [31:0] drop_count;
      logic        last;
   } rsp_type;

   // one ring slot as held in the slot memory
   typedef struct packed {
      logic [31:0] id;
      logic [63:0] hash;
      logic [1:0]  prio;
      logic        unread;
      logic [31:0] payload;
   } slot_type;

endpackage

// ----- hdl/dmrs_slot_mem.sv -----
// Slot memory: one write port, one read port with registered read data.
module dmrs_slot_mem #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  dmrs_pkg::slot_type  wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output dmrs_pkg::slot_type  rd_data
);
   import dmrs_pkg::*;

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/dedup_message_ring_store.sv -----
// Top level of the deduplicating message ring store.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  req     | in        | req_valid/req_ready  | req_data  (dmrs_pkg::req_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data  (dmrs_pkg::rsp_type)
//
// Publish may walk the live slots for a dedupe match, else writes the head slot;
// get/set walk from the oldest slot, snapshot from the newest with response stalls;
// clear and rejected requests respond directly. Walks read one slot per cycle unless
// a snapshot entry stalls; the next request is taken as rsp_valid rises, even while
// that response waits. Synchronous reset clears control state, not slot contents.
module dedup_message_ring_store #(
   parameter int RING_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dmrs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dmrs_pkg::rsp_type rsp_data
);
   import dmrs_pkg::*;

   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(RING_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_PUB_RD,
      S_PUB_WR,
      S_RESP
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   unread_ff, unread_in;
   logic [31:0]        next_id_ff, next_id_in;
   logic [31:0]        drop_ff, drop_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [6:0]         emit_ff, emit_in;
   logic [6:0]         match_ff, match_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               res_valid_ff, res_valid_in;
   slot_type           res_ent_ff, res_ent_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               rd_en, wr_en;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   slot_type           rd_data, wr_data;

   logic               out_free;
   logic [SUM_W-1:0]   oldest_sum;
   logic [ADDR_W-1:0]  oldest_ptr, newest_ptr, ptr_fwd, ptr_back, head_next;
   logic [CNT_W-1:0]   unread_tmp;
   logic               is_snap, is_find, stop, stall, want, full;
   logic [31:0]        id_inc;

   dmrs_slot_mem #(
      .DEPTH (RING_DEPTH)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ring pointer arithmetic
   always_comb begin
      oldest_sum = SUM_W'(head_ff) + SUM_W'(RING_DEPTH) - SUM_W'(fill_ff);
      if (oldest_sum >= SUM_W'(RING_DEPTH)) begin
         oldest_sum = oldest_sum - SUM_W'(RING_DEPTH);
      end
      oldest_ptr = oldest_sum[ADDR_W-1:0];
      newest_ptr = (head_ff == '0) ? LAST_ADDR : head_ff - 1'b1;
      ptr_fwd    = (ptr_ff == LAST_ADDR) ? '0 : ptr_ff + 1'b1;
      ptr_back   = (ptr_ff == '0) ? LAST_ADDR : ptr_ff - 1'b1;
      head_next  = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
      id_inc     = next_id_ff + 32'd1;
      full       = (fill_ff == FULL_CNT);
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      unread_in     = unread_ff;
      next_id_in    = next_id_ff;
      drop_in       = drop_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      emit_in       = emit_ff;
      match_in      = match_ff;
      res_status_in = res_status_ff;
      res_valid_in  = res_valid_ff;
      res_ent_in    = res_ent_ff;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff;
      wr_en         = 1'b0;
      wr_addr       = pend_addr_ff;
      wr_data       = rd_data;
      stop          = 1'b0;
      stall         = 1'b0;
      want          = 1'b0;
      unread_tmp    = unread_ff;
      is_snap       = (req_ff.cmd == CMD_SNAPSHOT);
      is_find       = (req_ff.cmd == CMD_GET) || (req_ff.cmd == CMD_SET);

      out_free      = !rsp_valid_ff || rsp_ready;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               idx_in        = '0;
               pend_in       = 1'b0;
               emit_in       = '0;
               match_in      = '0;
               res_status_in = STATUS_OK;
               res_valid_in  = 1'b0;
               res_ent_in    = '0;
               state_in      = S_RESP;
               unique case (req_data.cmd)
                  CMD_PUBLISH: begin
                     if (!req_data.content_ok) begin
                        res_status_in = STATUS_INVALID;
                     end else if (req_data.key_hash != '0 && fill_ff != '0) begin
                        ptr_in   = oldest_ptr;
                        state_in = S_WALK;
                     end else begin
                        state_in = S_PUB_RD;
                     end
                  end
                  CMD_GET, CMD_SET: begin
                     if (req_data.lookup_id == '0) begin
                        res_status_in = STATUS_INVALID;
                     end else if (fill_ff == '0) begin
                        res_status_in = STATUS_NOT_FOUND;
                     end else begin
                        ptr_in   = oldest_ptr;
                        state_in = S_WALK;
                     end
                  end
                  CMD_SNAPSHOT: begin
                     if (fill_ff != '0) begin
                        ptr_in   = newest_ptr;
                        state_in = S_WALK;
                     end
                  end
                  CMD_CLEAR: begin
                     head_in    = '0;
                     fill_in    = '0;
                     unread_in  = '0;
                     drop_in    = '0;
                     next_id_in = 32'd1;
                  end
                  default: begin
                     res_status_in = STATUS_INVALID;
                  end
               endcase
            end
         end

         S_WALK: begin
            // judge the slot read in the previous cycle
            if (pend_ff) begin
               if (is_snap) begin
                  if (!req_ff.unread_filter || rd_data.unread) begin
                     if (emit_ff < req_ff.snapshot_limit) begin
                        if (out_free) begin
                           rsp_in.status        = STATUS_OK;
                           rsp_in.entry_valid   = 1'b1;
                           rsp_in.entry_id      = rd_data.id;
                           rsp_in.entry_prio    = rd_data.prio;
                           rsp_in.entry_unread  = rd_data.unread;
                           rsp_in.entry_payload = rd_data.payload;
                           rsp_in.matched_total = '0;
                           rsp_in.stored_count  = OUT_CNT_W'(fill_ff);
                           rsp_in.unread_count  = OUT_CNT_W'(unread_ff);
                           rsp_in.drop_count    = drop_ff;
                           rsp_in.last          = 1'b0;
                           rsp_valid_in         = 1'b1;
                           emit_in              = emit_ff + 7'd1;
                           match_in             = match_ff + 7'd1;
                        end else begin
                           stall = 1'b1;
                        end
                     end else begin
                        match_in = match_ff + 7'd1;
                     end
                  end
               end else if (is_find) begin
                  if (rd_data.id == req_ff.lookup_id) begin
                     stop         = 1'b1;
                     res_valid_in = 1'b1;
                     res_ent_in   = rd_data;
                     state_in     = S_RESP;
                     if (req_ff.cmd == CMD_GET) begin
                        if (req_ff.mark_flag && rd_data.unread) begin
                           wr_en          = 1'b1;
                           wr_data.unread = 1'b0;
                           if (unread_ff != '0) begin
                              unread_in = unread_ff - 1'b1;
                           end
                        end
                     end else begin
                        want = !req_ff.mark_flag;
                        if (rd_data.unread != want) begin
                           wr_en          = 1'b1;
                           wr_data.unread = want;
                           if (want) begin
                              unread_in = unread_ff + 1'b1;
                           end else if (unread_ff != '0) begin
                              unread_in = unread_ff - 1'b1;
                           end
                        end
                     end
                  end
               end else begin
                  // publish dedupe hit returns the stored slot untouched
                  if (rd_data.hash == req_ff.key_hash) begin
                     stop         = 1'b1;
                     res_valid_in = 1'b1;
                     res_ent_in   = rd_data;
                     state_in     = S_RESP;
                  end
               end
            end

            // issue the next read or finish the walk
            if (!stop && !stall) begin
               if (idx_ff != fill_ff) begin
                  rd_en        = 1'b1;
                  rd_addr      = ptr_ff;
                  pend_addr_in = ptr_ff;
                  ptr_in       = is_snap ? ptr_back : ptr_fwd;
                  idx_in       = idx_ff + 1'b1;
                  pend_in      = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     if (is_snap) begin
                        state_in = S_RESP;
                     end else if (is_find) begin
                        res_status_in = STATUS_NOT_FOUND;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_PUB_RD;
                     end
                  end
               end
            end
         end

         S_PUB_RD: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            state_in = S_PUB_WR;
         end

         S_PUB_WR: begin
            // overwrite of the oldest slot when the ring is full
            if (full) begin
               drop_in = drop_ff + 32'd1;
               if (rd_data.unread && unread_ff != '0) begin
                  unread_tmp = unread_ff - 1'b1;
               end
            end else begin
               fill_in = fill_ff + 1'b1;
            end
            unread_in       = unread_tmp + 1'b1;
            wr_en           = 1'b1;
            wr_addr         = head_ff;
            wr_data.id      = next_id_ff;
            wr_data.hash    = req_ff.key_hash;
            wr_data.prio    = req_ff.prio;
            wr_data.unread  = 1'b1;
            wr_data.payload = req_ff.payload_tag;
            res_ent_in      = wr_data;
            res_valid_in    = 1'b1;
            head_in         = head_next;
            next_id_in      = (id_inc == '0) ? 32'd1 : id_inc;
            state_in        = S_RESP;
         end

         S_RESP: begin
            if (out_free) begin
               rsp_in.status        = res_status_ff;
               rsp_in.entry_valid   = res_valid_ff;
               rsp_in.entry_id      = res_ent_ff.id;
               rsp_in.entry_prio    = res_ent_ff.prio;
               rsp_in.entry_unread  = res_ent_ff.unread;
               rsp_in.entry_payload = res_ent_ff.payload;
               rsp_in.matched_total = match_ff;
               rsp_in.stored_count  = OUT_CNT_W'(fill_ff);
               rsp_in.unread_count  = OUT_CNT_W'(unread_ff);
               rsp_in.drop_count    = drop_ff;
               rsp_in.last          = 1'b1;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         unread_ff    <= '0;
         next_id_ff   <= 32'd1;
         drop_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         unread_ff    <= unread_in;
         next_id_ff   <= next_id_in;
         drop_ff      <= drop_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      ptr_ff        <= ptr_in;
      idx_ff        <= idx_in;
      pend_addr_ff  <= pend_addr_in;
      emit_ff       <= emit_in;
      match_ff      <= match_in;
      res_status_ff <= res_status_in;
      res_valid_ff  <= res_valid_in;
      res_ent_ff    <= res_ent_in;
      rsp_ff        <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/dmrs_checker.sv -----
// Port-level checker for the message ring store, bound to the top level.
`include "assert_macros.svh"

module dmrs_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dmrs_pkg::rsp_type rsp_data
);
   import dmrs_pkg::*;

   // a stalled response stays put
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")

   // responses without an entry carry zero entry fields
   `CHK_IMPLY(a_empty_entry, clock, reset, rsp_valid && !rsp_data.entry_valid, rsp_data.entry_id == 32'd0 && rsp_data.entry_payload == 32'd0 && rsp_data.entry_prio == 2'd0 && !rsp_data.entry_unread, "entry fields set without entry")

   // only snapshot entries come before the final response
   `CHK_IMPLY(a_mid_entry, clock, reset, rsp_valid && !rsp_data.last, rsp_data.entry_valid && rsp_data.status == STATUS_OK, "non-final response is not an entry")

   // unread entries are a subset of stored entries
   `CHK_IMPLY(a_unread_le, clock, reset, rsp_valid, rsp_data.unread_count <= rsp_data.stored_count, "unread count exceeds stored count")

   // a match total appears only on the snapshot summary
   `CHK_IMPLY(a_summary, clock, reset, rsp_valid && rsp_data.matched_total != 7'd0, !rsp_data.entry_valid && rsp_data.last, "match total outside summary")

endmodule

bind dedup_message_ring_store dmrs_checker u_dmrs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the deduplicating message ring store.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dmrs_pkg::*;

   localparam int RING_SLOTS   = 32;
   localparam int NUM_RANDOM   = 400;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AT      = 150;
   localparam int TAIL_CYCLES  = RING_SLOTS + 8;
   localparam int LIMIT_CYCLES = 1_000_000;

   // spare command codes, all rejected by the block
   localparam logic [2:0] CMD_SPARE_A = 3'd5;
   localparam logic [2:0] CMD_SPARE_B = 3'd6;
   localparam logic [2:0] CMD_SPARE_C = 3'd7;

   // Mirror of the ring plus the queue of responses still owed by the block.
   class ring_scoreboard;
      bit [31:0]   slot_id[RING_SLOTS];
      bit [63:0]   slot_hash[RING_SLOTS];
      bit [1:0]    slot_prio[RING_SLOTS];
      bit          slot_unread[RING_SLOTS];
      bit [31:0]   slot_payload[RING_SLOTS];
      int unsigned head;
      int unsigned fill;
      int unsigned unread_cnt;
      bit [31:0]   next_id;
      bit [31:0]   drops;
      rsp_type     owed[$];
      int          errors;
      int          requests;
      int          responses;
      int          snapshots;
      int          dedupe_hits;
      int          overwrites;

      function new();
         head       = 0;
         fill       = 0;
         unread_cnt = 0;
         next_id    = 1;
         drops      = 0;
      endfunction

      // response carrying slot 'slot' (or none when negative) and current counts
      function rsp_type report(logic [1:0] st, int slot, int unsigned matched, bit last_flag);
         rsp_type r;
         r = '0;
         r.status = st;
         if (slot >= 0) begin
            r.entry_valid   = 1'b1;
            r.entry_id      = slot_id[slot];
            r.entry_prio    = slot_prio[slot];
            r.entry_unread  = slot_unread[slot];
            r.entry_payload = slot_payload[slot];
         end
         r.matched_total = 7'(matched);
         r.stored_count  = 7'(fill);
         r.unread_count  = 7'(unread_cnt);
         r.drop_count    = drops;
         r.last          = last_flag;
         return r;
      endfunction

      // position of the i-th oldest live slot
      function int unsigned age_slot(int unsigned i);
         return (head + RING_SLOTS - fill + i) % RING_SLOTS;
      endfunction

      function void note_request(req_type q);
         int          found;
         int unsigned w;
         int unsigned x;
         int unsigned matched;
         int unsigned k;
         bit          was_unread;
         rsp_type     r;
         requests++;
         case (q.cmd)
            CMD_PUBLISH: begin
               if (!q.content_ok) begin
                  owed.push_back(report(STATUS_INVALID, -1, 0, 1'b1));
                  return;
               end
               // dedupe: oldest live slot with the same nonzero hash wins
               if (q.key_hash != 0) begin
                  for (int unsigned i = 0; i < fill; i++) begin
                     x = age_slot(i);
                     if (slot_hash[x] == q.key_hash) begin
                        dedupe_hits++;
                        owed.push_back(report(STATUS_OK, x, 0, 1'b1));
                        return;
                     end
                  end
               end
               w = head;
               // full ring: the oldest slot is overwritten
               if (fill >= RING_SLOTS) begin
                  if (slot_unread[w] && unread_cnt > 0)
                     unread_cnt--;
                  drops++;
                  overwrites++;
               end
               slot_hash[w]    = q.key_hash;
               slot_id[w]      = next_id;
               slot_prio[w]    = q.prio;
               slot_unread[w]  = 1'b1;
               slot_payload[w] = q.payload_tag;
               next_id++;
               if (next_id == 0)
                  next_id = 1;
               head = (w + 1) % RING_SLOTS;
               if (fill < RING_SLOTS)
                  fill++;
               unread_cnt++;
               owed.push_back(report(STATUS_OK, w, 0, 1'b1));
            end
            CMD_GET, CMD_SET: begin
               if (q.lookup_id == 0) begin
                  owed.push_back(report(STATUS_INVALID, -1, 0, 1'b1));
                  return;
               end
               found = -1;
               for (int unsigned i = 0; i < fill && found < 0; i++) begin
                  x = age_slot(i);
                  if (slot_id[x] == q.lookup_id)
                     found = x;
               end
               if (found < 0) begin
                  owed.push_back(report(STATUS_NOT_FOUND, -1, 0, 1'b1));
                  return;
               end
               was_unread = slot_unread[found];
               if (q.cmd == CMD_GET) begin
                  if (q.mark_flag && was_unread) begin
                     slot_unread[found] = 1'b0;
                     if (unread_cnt > 0)
                        unread_cnt--;
                  end
               end else if (was_unread != !q.mark_flag) begin
                  slot_unread[found] = !q.mark_flag;
                  if (!q.mark_flag)
                     unread_cnt++;
                  else if (unread_cnt > 0)
                     unread_cnt--;
               end
               r = report(STATUS_OK, found, 0, 1'b1);
               r.entry_unread = was_unread;
               owed.push_back(r);
            end
            CMD_SNAPSHOT: begin
               // newest first, up to the limit, then a summary
               snapshots++;
               matched = 0;
               k = 0;
               for (int unsigned i = 0; i < fill; i++) begin
                  x = (head + RING_SLOTS - 1 - i) % RING_SLOTS;
                  if (q.unread_filter && !slot_unread[x])
                     continue;
                  matched++;
                  if (k < q.snapshot_limit) begin
                     owed.push_back(report(STATUS_OK, x, 0, 1'b0));
                     k++;
                  end
               end
               owed.push_back(report(STATUS_OK, -1, matched, 1'b1));
            end
            CMD_CLEAR: begin
               fill       = 0;
               head       = 0;
               unread_cnt = 0;
               drops      = 0;
               next_id    = 1;
               owed.push_back(report(STATUS_OK, -1, 0, 1'b1));
            end
            default: owed.push_back(report(STATUS_INVALID, -1, 0, 1'b1));
         endcase
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         responses++;
         if (owed.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = owed.pop_front();
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
         compare_field("entry_id", 64'(want.entry_id), 64'(got.entry_id));
         compare_field("entry_prio", 64'(want.entry_prio), 64'(got.entry_prio));
         compare_field("entry_unread", 64'(want.entry_unread), 64'(got.entry_unread));
         compare_field("entry_payload", 64'(want.entry_payload), 64'(got.entry_payload));
         compare_field("matched_total", 64'(want.matched_total), 64'(got.matched_total));
         compare_field("stored_count", 64'(want.stored_count), 64'(got.stored_count));
         compare_field("unread_count", 64'(want.unread_count), 64'(got.unread_count));
         compare_field("drop_count", 64'(want.drop_count), 64'(got.drop_count));
         compare_field("last", 64'(want.last), 64'(got.last));
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   ring_scoreboard sb;
   int sent_count;
   int taken_count;
   int cycles;

   dedup_message_ring_store #(
      .RING_DEPTH(RING_SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // every third stretch of 32 items runs without idle cycles
   function automatic int draw_gap(int n);
      return ((n / 32) % 3 == 2) ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic req_type make_req(logic [2:0] cmd, logic [31:0] id, logic mark,
                                        logic [63:0] hash, logic [1:0] prio,
                                        logic [31:0] payload, logic ok,
                                        logic unread_filter, logic [6:0] limit);
      req_type r;
      r.cmd            = cmd;
      r.lookup_id      = id;
      r.mark_flag      = mark;
      r.key_hash       = hash;
      r.prio           = prio;
      r.payload_tag    = payload;
      r.content_ok     = ok;
      r.unread_filter  = unread_filter;
      r.snapshot_limit = limit;
      return r;
   endfunction

   // Offer one request; called and returns at a falling edge.
   task automatic send_request(req_type r);
      int gap;
      gap = draw_gap(sent_count);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      sent_count++;
      @(negedge clock);
   endtask

   // Response side: random stalls, one long hold-off to back up the block.
   initial begin
      int gap;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         gap = (taken_count == HOLD_AT) ? LONG_HOLD : draw_gap(taken_count);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
         taken_count++;
         @(negedge clock);
      end
   end

   // Watchdog.
   initial begin
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Main sequence: directed requests, then random traffic.
   initial begin
      req_type     r;
      req_type     directed[$];
      bit [63:0]   hash_pool[8];
      bit [63:0]   all_ones;
      int          roll;
      int          pick;
      sb = new();
      all_ones = '1;
      foreach (hash_pool[i])
         hash_pool[i] = {$urandom, $urandom} | 64'h1;

      // empty ring, rejected commands and lookups
      directed.push_back(make_req(CMD_GET, 0, 1, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_SET, 5, 1, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 1, 0, 64));
      directed.push_back(make_req(CMD_SPARE_A, 1, 1, 1, 1, 1, 1, 1, 1));
      directed.push_back(make_req(CMD_SPARE_B, 0, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_SPARE_C, '1, 1, '1, 3, '1, 1, 1, 127));
      // bad content, field extremes, zero hash never dedupes, then a dedupe hit
      directed.push_back(make_req(CMD_PUBLISH, 0, 0, 7, 2, 32'h1234, 0, 0, 0));
      directed.push_back(make_req(CMD_PUBLISH, 0, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_PUBLISH, 0, 0, all_ones, 3, '1, 1, 0, 0));
      directed.push_back(make_req(CMD_PUBLISH, 0, 0, 0, 1, 32'h55, 1, 0, 0));
      directed.push_back(make_req(CMD_PUBLISH, 0, 0, all_ones, 2, 32'h77, 1, 0, 0));
      // read marking: get with and without mark, set both ways, no-op set
      directed.push_back(make_req(CMD_GET, 1, 1, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_GET, 1, 1, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_GET, 2, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_SET, 2, 1, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_SET, 1, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_SET, 1, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_GET, '1, 1, 0, 0, 0, 1, 0, 0));
      // snapshot filter and limits
      directed.push_back(make_req(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 1, 1, 1));
      directed.push_back(make_req(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 1, 0, 127));
      // clear, then old ids and hashes are gone
      directed.push_back(make_req(CMD_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_GET, 1, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_req(CMD_PUBLISH, 0, 0, all_ones, 1, 32'h99, 1, 0, 0));
      directed.push_back(make_req(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 1, 0, 64));

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_request(directed[i]);

      repeat (NUM_RANDOM) begin
         r = make_req(CMD_PUBLISH, $urandom, 1'($urandom_range(0, 1)), {$urandom, $urandom},
                      2'($urandom_range(0, 3)), $urandom, ($urandom_range(0, 15) != 0),
                      1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            // publish: mix of no key, recurring keys and fresh keys
            pick = $urandom_range(0, 3);
            if (pick == 0)
               r.key_hash = '0;
            else if (pick < 3)
               r.key_hash = hash_pool[$urandom_range(0, 7)];
         end else if (roll < 74) begin
            r.cmd = (roll < 62) ? CMD_GET : CMD_SET;
            // mostly ids near the live window, some zero, some arbitrary
            pick = $urandom_range(0, 9);
            if (pick == 0)
               r.lookup_id = '0;
            else if (pick > 1)
               r.lookup_id = sb.next_id - 1 - $urandom_range(0, sb.fill);
         end else if (roll < 88) begin
            r.cmd = CMD_SNAPSHOT;
            pick = $urandom_range(0, 9);
            if (pick < 4)
               r.snapshot_limit = 7'($urandom_range(0, 6));
            else if (pick < 7)
               r.snapshot_limit = 7'd64;
         end else if (roll < 89) begin
            r.cmd = CMD_CLEAR;
         end else if (roll < 92) begin
            r.cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
         end else begin
            r.cmd = 3'($urandom_range(CMD_PUBLISH, CMD_SPARE_C));
         end
         send_request(r);
      end
      req_valid <= 1'b0;

      // drain, then watch for stray responses
      while (sb.owed.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d requests and checked %0d responses, %0d of them snapshot walks.",
               sb.requests, sb.responses, sb.snapshots);
      $display("Saw %0d dedupe hits and %0d overwrites of the oldest slot; %0d mismatches.",
               sb.dedupe_hits, sb.overwrites, sb.errors);
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
